@@ sv/tva_pkg.sv @@
package tva_pkg;

   // default channel count and fixed field widths
   localparam int TVA_MAX_CHANNELS = 4;
   localparam int TVA_IDX_W        = 4;   // holds any channel index up to sixteen channels
   localparam int TVA_CNT_W        = 5;   // holds a channel count up to sixteen
   localparam int TVA_CFG_W        = 3;
   localparam int TVA_HZ_W         = 16;
   localparam int TVA_TIME_W       = 32;
   localparam int TVA_STATUS_W     = 2;
   localparam int TVA_CHAN_W       = 2;

   localparam logic [TVA_CFG_W-1:0] TVA_CFG_RESET = 3'd4;

   localparam logic FUNC_PRESS   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef enum logic [TVA_STATUS_W-1:0] {
      ST_FREE    = 2'd0,
      ST_STOLEN  = 2'd1,
      ST_CLEARED = 2'd2,
      ST_NOMATCH = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CTRL_IDLE = 2'd0,
      CTRL_SCAN = 2'd1,
      CTRL_DONE = 2'd2
   } ctrl_state_type;

   // scan token passed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic [TVA_IDX_W-1:0]  hit_idx;
      logic [TVA_IDX_W-1:0]  old_idx;
      logic [TVA_TIME_W-1:0] old_start;
   } token_type;

   // request fields broadcast to all cells during a scan
   typedef struct packed {
      logic                 func;
      logic [TVA_HZ_W-1:0]  hz;
      logic [TVA_CNT_W-1:0] count;
   } scan_cmd_type;

   // channel write broadcast after a scan
   typedef struct packed {
      logic                  en;
      logic [TVA_IDX_W-1:0]  idx;
      logic [TVA_HZ_W-1:0]   tone;
      logic [TVA_TIME_W-1:0] start;
   } wr_cmd_type;

endpackage

@@ sv/tva_req_if.sv @@
interface tva_req_if import tva_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [TVA_HZ_W-1:0]   tone_hz;
   logic [TVA_TIME_W-1:0] now_ms;

   modport source (output valid, output func, output tone_hz, output now_ms, input ready);
   modport sink (input valid, input func, input tone_hz, input now_ms, output ready);
endinterface

@@ sv/tva_rsp_if.sv @@
interface tva_rsp_if import tva_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [TVA_STATUS_W-1:0] status;
   logic [TVA_CHAN_W-1:0]   channel;
   logic [TVA_HZ_W-1:0]     drive_hz;

   modport source (output valid, output status, output channel, output drive_hz, input ready);
   modport sink (input valid, input status, input channel, input drive_hz, output ready);
endinterface

@@ sv/tva_cell.sv @@
module tva_cell import tva_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [TVA_IDX_W-1:0] cell_idx,
   input  scan_cmd_type         cmd,
   input  wr_cmd_type           wr,
   input  token_type            tok_left,
   output token_type            tok_right
);

   logic [TVA_HZ_W-1:0]   tone_ff;
   logic [TVA_TIME_W-1:0] start_ff;
   token_type             tok_ff, tok_in;
   logic                  active;

   // cells past the channel count pass the token on untouched
   assign active = ({1'b0, cell_idx} < cmd.count);

   always_comb begin
      tok_in = tok_left;
      if (tok_left.valid && active && !tok_left.hit) begin
         if (cmd.func == FUNC_PRESS) begin
            if (tone_ff == '0) begin
               tok_in.hit     = 1'b1;
               tok_in.hit_idx = cell_idx;
            end else if (cell_idx == '0 || start_ff < tok_left.old_start) begin
               tok_in.old_idx   = cell_idx;
               tok_in.old_start = start_ff;
            end
         end else if (tone_ff == cmd.hz) begin
            tok_in.hit     = 1'b1;
            tok_in.hit_idx = cell_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_ff      <= '0;
         start_ff     <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
         if (wr.en && wr.idx == cell_idx) begin
            tone_ff  <= wr.tone;
            start_ff <= wr.start;
         end
      end
      // token payload needs no reset, only valid qualifies it
      tok_ff.hit       <= tok_in.hit;
      tok_ff.hit_idx   <= tok_in.hit_idx;
      tok_ff.old_idx   <= tok_in.old_idx;
      tok_ff.old_start <= tok_in.old_start;
   end

   assign tok_right = tok_ff;

endmodule

@@ sv/tva_ctrl.sv @@
module tva_ctrl import tva_pkg::*; #(
   parameter int MAX_CHANNELS = TVA_MAX_CHANNELS
) (
   input  logic                 clock,
   input  logic                 reset,
   tva_req_if.sink              req_chan,
   tva_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [TVA_CFG_W-1:0] csr_wr_data,
   output scan_cmd_type         cmd,
   output token_type            tok_head,
   input  token_type            tok_tail,
   output wr_cmd_type           wr
);

   ctrl_state_type        state_ff, state_in;
   logic [TVA_CFG_W-1:0]  cfg_ff;
   logic [TVA_CNT_W-1:0]  count;
   logic                  launch_ff;
   logic                  func_ff;
   logic [TVA_HZ_W-1:0]   hz_ff;
   logic [TVA_TIME_W-1:0] now_ff;
   token_type             hold_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, status_in;
   logic [TVA_CHAN_W-1:0] rsp_channel_ff;
   logic [TVA_HZ_W-1:0]   rsp_drive_ff, drive_in;
   logic [TVA_IDX_W-1:0]  idx_in;
   logic                  wr_need;
   logic                  accept;
   logic                  fire;

   // zero acts as one channel, anything above the chain length as the full chain
   always_comb begin
      if (cfg_ff == '0) begin
         count = TVA_CNT_W'(1);
      end else if (TVA_CNT_W'(cfg_ff) > TVA_CNT_W'(MAX_CHANNELS)) begin
         count = TVA_CNT_W'(MAX_CHANNELS);
      end else begin
         count = TVA_CNT_W'(cfg_ff);
      end
   end

   assign req_chan.ready = (state_ff == CTRL_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign fire           = (state_ff == CTRL_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign cmd.func  = func_ff;
   assign cmd.hz    = hz_ff;
   assign cmd.count = count;

   assign tok_head.valid     = launch_ff;
   assign tok_head.hit       = 1'b0;
   assign tok_head.hit_idx   = '0;
   assign tok_head.old_idx   = '0;
   assign tok_head.old_start = '0;

   // outcome of the finished scan
   always_comb begin
      wr_need   = 1'b1;
      status_in = ST_NOMATCH;
      idx_in    = '0;
      drive_in  = '0;
      wr.tone   = '0;
      wr.start  = '0;
      if (func_ff == FUNC_PRESS) begin
         status_in = hold_ff.hit ? ST_FREE : ST_STOLEN;
         idx_in    = hold_ff.hit ? hold_ff.hit_idx : hold_ff.old_idx;
         drive_in  = hz_ff;
         wr.tone   = hz_ff;
         wr.start  = (hz_ff != '0) ? now_ff : '0;
      end else if (hold_ff.hit) begin
         status_in = ST_CLEARED;
         idx_in    = hold_ff.hit_idx;
      end else begin
         wr_need = 1'b0;
      end
      wr.en  = fire && wr_need;
      wr.idx = idx_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         CTRL_IDLE: begin
            if (accept) begin
               state_in = CTRL_SCAN;
            end
         end
         CTRL_SCAN: begin
            if (tok_tail.valid) begin
               state_in = CTRL_DONE;
            end
         end
         CTRL_DONE: begin
            if (fire) begin
               state_in     = CTRL_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         cfg_ff       <= TVA_CFG_RESET;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= accept;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_chan.func;
         hz_ff   <= req_chan.tone_hz;
         now_ff  <= req_chan.now_ms;
      end
      if (state_ff == CTRL_SCAN && tok_tail.valid) begin
         hold_ff <= tok_tail;
      end
      if (fire) begin
         rsp_status_ff  <= status_in;
         rsp_channel_ff <= TVA_CHAN_W'(idx_in);
         rsp_drive_ff   <= drive_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.channel  = rsp_channel_ff;
   assign rsp_chan.drive_hz = rsp_drive_ff;

`ifndef ASSERT_OFF
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_tail.valid |-> state_ff == CTRL_SCAN)
      else $error("scan token left the chain outside a scan");

   a_write_in_done: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> state_ff == CTRL_DONE && state_in == CTRL_IDLE)
      else $error("channel write outside response handoff");

   a_launch_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> launch_ff && state_ff == CTRL_SCAN)
      else $error("accepted request did not launch a scan");

   a_nomatch_silent: assert property (@(posedge clock) disable iff (reset)
      fire && status_in == ST_NOMATCH |-> !wr.en && drive_in == '0 && idx_in == '0)
      else $error("unmatched release wrote a channel");
`endif

endmodule

@@ sv/tone_voice_allocator.sv @@
// tone voice allocator: keeps a tone and a start time for each of up to
// MAX_CHANNELS output channels, one channel per cell in a chain. a key press
// (func 0) takes the first free channel among the first channels_in_use,
// or steals the one with the oldest start time (lowest index on a tie); a
// release (func 1) silences the first channel playing the given tone. the
// response carries the status, the channel written and the tone now driven.
// one request is handled at a time from acceptance until the next request
// can be taken: the scan token steps through one cell per cycle, then the
// chosen channel is written as the response is loaded. a new request is
// accepted while the previous response is still waiting on rsp_chan.
// csr_wr_data sets channels_in_use (reset 4, 0 acts as 1, larger than the
// chain acts as the full chain); the user must write it only while no
// request is in flight, as the block itself does not enforce this.
module tone_voice_allocator import tva_pkg::*; #(
   parameter int MAX_CHANNELS = TVA_MAX_CHANNELS
) (
   input  logic                 clock,
   input  logic                 reset,
   tva_req_if.sink              req_chan,
   tva_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [TVA_CFG_W-1:0] csr_wr_data
);

   // token path: tok[0] enters the first cell, tok[MAX_CHANNELS] leaves the last
   token_type    tok [MAX_CHANNELS+1];
   scan_cmd_type cmd;
   wr_cmd_type   wr;

   // sequencer: config register, request capture, decision and response
   tva_ctrl #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .tok_head    (tok[0]),
      .tok_tail    (tok[MAX_CHANNELS]),
      .wr          (wr)
   );

   // one cell per channel, each holding that channel's tone and start time
   for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_cell
      tva_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (TVA_IDX_W'(k)),
         .cmd       (cmd),
         .wr        (wr),
         .tok_left  (tok[k]),
         .tok_right (tok[k+1])
      );
   end

endmodule
